>>> rtl/assert_macros.svh
// Assertion macros used by the port-level checker, bole_chk.
// Expects clk and rst_n in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define CHK_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define CHK_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> rtl/bole_pkg.sv
// Package for the ordered list engine: field widths, request codes,
// entry type and the controller/datapath command and status structs.
package bole_pkg;

  localparam int KIND_W  = 3;
  localparam int POS_W   = 7;
  localparam int ID_W    = 16;
  localparam int DATA_W  = 16;
  localparam int FPOS_W  = 6;
  localparam int LEN_W   = 7;
  localparam int MAXSZ_W = 7;
  localparam int APB_AW  = 3;
  localparam int APB_DW  = 32;

  localparam logic [MAXSZ_W-1:0] MAX_SIZE_RST = 7'd64;
  localparam logic [0:0]         REG_MAX_SIZE = 1'b0;

  localparam logic [KIND_W-1:0] KIND_INSERT_AT    = 3'd0;
  localparam logic [KIND_W-1:0] KIND_REMOVE_AT    = 3'd1;
  localparam logic [KIND_W-1:0] KIND_REMOVE_BY_ID = 3'd2;
  localparam logic [KIND_W-1:0] KIND_READ_AT      = 3'd3;
  localparam logic [KIND_W-1:0] KIND_FIND         = 3'd4;
  localparam logic [KIND_W-1:0] KIND_CLEAR        = 3'd5;
  localparam logic [KIND_W-1:0] KIND_INSERT_HEAD  = 3'd6;
  localparam logic [KIND_W-1:0] KIND_INSERT_TAIL  = 3'd7;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [DATA_W-1:0] data;
  } entry_t;

  typedef struct packed {
    logic load;
    logic init_bw;
    logic init_fw;
    logic issue;
    logic dn;
    logic walk_bw;
    logic walk_fw;
    logic put;
    logic rem_done;
    logic read_cap;
    logic clr;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              ins_ok;
    logic              ins_shift;
    logic              pos_in_range;
    logic              nonempty;
    logic              bw_last;
    logic              fw_end;
    logic              find_hit;
  } dp_stat_t;

endpackage

>>> rtl/bole_ifs.sv
// Request and response channel interfaces (valid/ready).
// Depends on bole_pkg for field widths.
interface bole_req_if import bole_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [POS_W-1:0]  position;
  logic [ID_W-1:0]   entry_id;
  logic [DATA_W-1:0] data_value;

  modport source (output valid, kind, position, entry_id, data_value, input ready);
  modport sink   (input valid, kind, position, entry_id, data_value, output ready);
endinterface

interface bole_rsp_if import bole_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              ok;
  logic [ID_W-1:0]   found_id;
  logic [DATA_W-1:0] found_data;
  logic [FPOS_W-1:0] found_position;
  logic [LEN_W-1:0]  length;
  logic              full_res;
  logic              empty_res;

  modport source (output valid, ok, found_id, found_data, found_position, length,
                  full_res, empty_res, input ready);
  modport sink   (input valid, ok, found_id, found_data, found_position, length,
                  full_res, empty_res, output ready);
endinterface

>>> rtl/bole_ctrl.sv
// Controller state machine of the ordered list engine.
// Depends on bole_pkg; drives bole_dp through dp_cmd_t / dp_stat_t.
module bole_ctrl import bole_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_START  = 4'd1;
  localparam logic [3:0] S_BWALK  = 4'd2;
  localparam logic [3:0] S_BDRAIN = 4'd3;
  localparam logic [3:0] S_PUT    = 4'd4;
  localparam logic [3:0] S_FWALK  = 4'd5;
  localparam logic [3:0] S_RISSUE = 4'd6;
  localparam logic [3:0] S_RCAP   = 4'd7;
  localparam logic [3:0] S_FIN    = 4'd8;

  logic [3:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_START;
        end
      end
      S_START: begin
        state_nxt = S_FIN;
        case (stat.kind)
          KIND_INSERT_AT, KIND_INSERT_HEAD, KIND_INSERT_TAIL: begin
            if (stat.ins_ok) begin
              if (stat.ins_shift) begin
                cmd.init_bw = 1'b1;
                state_nxt   = S_BWALK;
              end else begin
                state_nxt = S_PUT;
              end
            end
          end
          KIND_REMOVE_AT: begin
            if (stat.pos_in_range) begin
              cmd.init_fw = 1'b1;
              state_nxt   = S_FWALK;
            end
          end
          KIND_REMOVE_BY_ID, KIND_FIND: begin
            if (stat.nonempty) begin
              cmd.init_fw = 1'b1;
              state_nxt   = S_FWALK;
            end
          end
          KIND_READ_AT: begin
            if (stat.pos_in_range) begin
              cmd.init_fw = 1'b1;
              state_nxt   = S_RISSUE;
            end
          end
          KIND_CLEAR: begin
            cmd.clr = stat.nonempty;
          end
          default: state_nxt = S_FIN;
        endcase
      end
      S_BWALK: begin
        cmd.issue   = 1'b1;
        cmd.dn      = 1'b1;
        cmd.walk_bw = 1'b1;
        if (stat.bw_last) begin
          state_nxt = S_BDRAIN;
        end
      end
      S_BDRAIN: begin
        cmd.walk_bw = 1'b1;
        state_nxt   = S_PUT;
      end
      S_PUT: begin
        cmd.put   = 1'b1;
        state_nxt = S_FIN;
      end
      S_FWALK: begin
        cmd.issue   = 1'b1;
        cmd.walk_fw = 1'b1;
        if (stat.find_hit) begin
          state_nxt = S_FIN;
        end else if (stat.fw_end) begin
          cmd.rem_done = 1'b1;
          state_nxt    = S_FIN;
        end
      end
      S_RISSUE: begin
        cmd.issue = 1'b1;
        state_nxt = S_RCAP;
      end
      S_RCAP: begin
        cmd.read_cap = 1'b1;
        state_nxt    = S_FIN;
      end
      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

>>> rtl/bole_dp.sv
// Datapath of the ordered list engine: entry memory, walk cursor,
// request and result registers. Depends on bole_pkg; driven by bole_ctrl.
module bole_dp import bole_pkg::*; #(
  parameter int MAX_ENTRIES = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  dp_cmd_t             cmd,
  output dp_stat_t            stat,
  input  logic [MAXSZ_W-1:0]  max_size,
  input  logic [KIND_W-1:0]   req_kind,
  input  logic [POS_W-1:0]    req_position,
  input  logic [ID_W-1:0]     req_entry_id,
  input  logic [DATA_W-1:0]   req_data_value,
  output logic                o_ok,
  output logic [ID_W-1:0]     o_found_id,
  output logic [DATA_W-1:0]   o_found_data,
  output logic [FPOS_W-1:0]   o_found_position,
  output logic [LEN_W-1:0]    o_length,
  output logic                o_full,
  output logic                o_empty
);

  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int XW = (CW > LEN_W) ? CW : LEN_W;

  entry_t mem [MAX_ENTRIES];

  logic [KIND_W-1:0] kind_r;
  logic [POS_W-1:0]  pos_r;
  logic [ID_W-1:0]   key_id_r;
  logic [DATA_W-1:0] key_data_r;
  logic [CW-1:0]     count_r, count_nxt;
  logic [CW-1:0]     cur_r;
  logic [CW-1:0]     rda_r;
  logic              rdv_r;
  logic              shift_r;
  entry_t            rd_q;
  logic              ok_r;
  logic [ID_W-1:0]   fid_r;
  logic [DATA_W-1:0] fdata_r;
  logic [XW-1:0]     fpos_r;

  logic [ID_W-1:0]   o_fid_r;
  logic [DATA_W-1:0] o_fdata_r;
  logic [FPOS_W-1:0] o_fpos_r;
  logic [LEN_W-1:0]  o_len_r;
  logic              o_ok_r, o_full_r, o_empty_r;

  logic [XW-1:0] count_w, pos_w, max_w, ins_pos_w, pos_inc_w;
  logic [CW-1:0] ins_pos, fw_start, wa;
  logic          full, issue_go, wr_bw, wr_fw, we, id_hit, find_hit;
  entry_t        wd;

  assign count_w   = XW'(count_r);
  assign pos_w     = XW'(pos_r);
  assign max_w     = XW'(max_size);
  assign pos_inc_w = pos_w + XW'(1);
  assign full      = (count_w >= max_w) || (count_r >= CW'(MAX_ENTRIES));

  always_comb begin
    case (kind_r)
      KIND_INSERT_HEAD: ins_pos_w = '0;
      KIND_INSERT_TAIL: ins_pos_w = count_w;
      default:          ins_pos_w = pos_w;
    endcase
  end
  assign ins_pos = ins_pos_w[CW-1:0];

  always_comb begin
    case (kind_r)
      KIND_REMOVE_AT: fw_start = pos_inc_w[CW-1:0];
      KIND_READ_AT:   fw_start = pos_w[CW-1:0];
      default:        fw_start = '0;
    endcase
  end

  assign issue_go = cmd.issue && (cmd.dn || (cur_r < count_r));
  assign wr_bw    = cmd.walk_bw && rdv_r;
  assign wr_fw    = cmd.walk_fw && rdv_r && shift_r;
  assign id_hit   = rdv_r && (kind_r == KIND_REMOVE_BY_ID) && !shift_r
                    && (rd_q.id == key_id_r);
  assign find_hit = rdv_r && (kind_r == KIND_FIND) && (rd_q.data == key_data_r);

  always_comb begin
    we = 1'b1;
    wd = rd_q;
    wa = rda_r - CW'(1);
    if (cmd.put) begin
      wa = ins_pos;
      wd = '{id: key_id_r, data: key_data_r};
    end else if (wr_bw) begin
      wa = rda_r + CW'(1);
    end else if (!wr_fw) begin
      we = 1'b0;
    end
  end

  assign stat.kind         = kind_r;
  assign stat.ins_ok       = (ins_pos_w <= count_w) && !full;
  assign stat.ins_shift    = (ins_pos_w < count_w);
  assign stat.pos_in_range = (pos_w < count_w);
  assign stat.nonempty     = (count_r != '0);
  assign stat.bw_last      = (cur_r == ins_pos);
  assign stat.fw_end       = (cur_r >= count_r) && !rdv_r;
  assign stat.find_hit     = find_hit;

  // entry memory: at most one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa[AW-1:0]] <= wd;
    end
    if (issue_go) begin
      rd_q <= mem[cur_r[AW-1:0]];
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (cmd.put) begin
      count_nxt = count_r + CW'(1);
    end else if (cmd.rem_done && shift_r) begin
      count_nxt = count_r - CW'(1);
    end else if (cmd.clr) begin
      count_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      rdv_r   <= 1'b0;
      shift_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      rdv_r   <= issue_go;
      if (cmd.load) begin
        shift_r <= 1'b0;
      end else if (cmd.init_fw) begin
        shift_r <= (kind_r == KIND_REMOVE_AT);
      end else if (cmd.walk_fw && id_hit) begin
        shift_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r     <= req_kind;
      pos_r      <= req_position;
      key_id_r   <= req_entry_id;
      key_data_r <= req_data_value;
    end
    if (cmd.init_bw) begin
      cur_r <= count_r - CW'(1);
    end else if (cmd.init_fw) begin
      cur_r <= fw_start;
    end else if (issue_go) begin
      cur_r <= cmd.dn ? (cur_r - CW'(1)) : (cur_r + CW'(1));
    end
    if (issue_go) begin
      rda_r <= cur_r;
    end
    if (cmd.load) begin
      ok_r    <= 1'b0;
      fid_r   <= '0;
      fdata_r <= '0;
      fpos_r  <= '0;
    end else if (cmd.walk_fw && find_hit) begin
      ok_r    <= 1'b1;
      fid_r   <= rd_q.id;
      fdata_r <= rd_q.data;
      fpos_r  <= XW'(rda_r);
    end else if (cmd.read_cap) begin
      ok_r    <= 1'b1;
      fid_r   <= rd_q.id;
      fdata_r <= rd_q.data;
    end else if (cmd.put || cmd.clr || (cmd.rem_done && shift_r)) begin
      ok_r <= 1'b1;
    end
    if (cmd.out_load) begin
      o_ok_r    <= ok_r;
      o_fid_r   <= fid_r;
      o_fdata_r <= fdata_r;
      o_fpos_r  <= fpos_r[FPOS_W-1:0];
      o_len_r   <= count_w[LEN_W-1:0];
      o_full_r  <= full;
      o_empty_r <= (count_r == '0);
    end
  end

  assign o_ok             = o_ok_r;
  assign o_found_id       = o_fid_r;
  assign o_found_data     = o_fdata_r;
  assign o_found_position = o_fpos_r;
  assign o_length         = o_len_r;
  assign o_full           = o_full_r;
  assign o_empty          = o_empty_r;

endmodule

>>> rtl/bounded_ordered_list_engine_unit.sv
// Per request: an insert walks back over the entries from the position on and shifts them,
// remove, remove by id and find walk forward, read fetches one entry, and clear and rejected
// requests go straight to the result. One transaction at a time; the next is taken in the
// idle state after the result is registered, while that result may still wait on the output.
// Reset (rst_n, synchronous): list empty, max_size = 64; entry memory is not cleared.
// Depends on bole_pkg, bole_ifs, bole_ctrl and bole_dp.
module bounded_ordered_list_engine_unit import bole_pkg::*; #(
  parameter int MAX_ENTRIES = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  bole_req_if.sink            in_req,
  bole_rsp_if.source          out_rsp,
  input  logic                cfg_psel,
  input  logic                cfg_penable,
  input  logic                cfg_pwrite,
  input  logic [APB_AW-1:0]   cfg_paddr,
  input  logic [APB_DW-1:0]   cfg_pwdata,
  output logic [APB_DW-1:0]   cfg_prdata,
  output logic                cfg_pready
);

  logic [MAXSZ_W-1:0] max_size_r;
  logic               cfg_sel_max;
  dp_cmd_t            cmd;
  dp_stat_t           stat;

  assign cfg_pready  = 1'b1;
  assign cfg_sel_max = (cfg_paddr[APB_AW-1] == REG_MAX_SIZE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_size_r <= MAX_SIZE_RST;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_sel_max) begin
      max_size_r <= cfg_pwdata[MAXSZ_W-1:0];
    end
  end

  always_comb begin
    cfg_prdata = '0;
    if (cfg_sel_max) begin
      cfg_prdata = APB_DW'(max_size_r);
    end
  end

  bole_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_req.valid),
    .in_ready  (in_req.ready),
    .out_valid (out_rsp.valid),
    .out_ready (out_rsp.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  bole_dp #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .max_size         (max_size_r),
    .req_kind         (in_req.kind),
    .req_position     (in_req.position),
    .req_entry_id     (in_req.entry_id),
    .req_data_value   (in_req.data_value),
    .o_ok             (out_rsp.ok),
    .o_found_id       (out_rsp.found_id),
    .o_found_data     (out_rsp.found_data),
    .o_found_position (out_rsp.found_position),
    .o_length         (out_rsp.length),
    .o_full           (out_rsp.full_res),
    .o_empty          (out_rsp.empty_res)
  );

endmodule

>>> rtl/bole_chk.sv
// Port-level checker for the ordered list engine, bound to the top level.
// Depends on assert_macros.svh and bole_pkg.
`include "assert_macros.svh"
module bole_chk import bole_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic              ok,
  input logic [ID_W-1:0]   found_id,
  input logic [DATA_W-1:0] found_data,
  input logic [FPOS_W-1:0] found_position,
  input logic [LEN_W-1:0]  length,
  input logic              full_res,
  input logic              empty_res
);

  // one transaction in flight
  `CHK_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
  `CHK_SAME(a_empty_matches_len, out_valid, empty_res == (length == '0))
  `CHK_SAME(a_fail_clears_found, out_valid && !ok, (found_id == '0) && (found_data == '0) && (found_position == '0))
  `CHK_NEXT(a_rsp_held, out_valid && !out_ready, out_valid)
  `CHK_NEXT(a_rsp_stable, out_valid && !out_ready, $stable(ok) && $stable(found_id) && $stable(found_data) && $stable(length) && $stable(full_res))

endmodule

bind bounded_ordered_list_engine_unit bole_chk u_chk (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_req.valid),
  .in_ready       (in_req.ready),
  .out_valid      (out_rsp.valid),
  .out_ready      (out_rsp.ready),
  .ok             (out_rsp.ok),
  .found_id       (out_rsp.found_id),
  .found_data     (out_rsp.found_data),
  .found_position (out_rsp.found_position),
  .length         (out_rsp.length),
  .full_res       (out_rsp.full_res),
  .empty_res      (out_rsp.empty_res)
);
